[rtl/tsc_pkg.sv]
// shared types and constants of the touch relay switch controller
package tsc_pkg;

  typedef enum logic {
    CMD_PROCESS   = 1'b0,
    CMD_COUNTDOWN = 1'b1
  } cmd_e;

  // result word, first member in the highest bits
  typedef struct packed {
    logic       periodic_update;
    logic       start_pairing;
    logic [2:0] report_mask;
    logic       touch_led;
    logic       sensor_led;
    logic [2:0] led_blue;
    logic [2:0] led_red;
    logic [2:0] relay_on;
  } result_t;

  parameter logic [12:0] UPDATE_PERIOD   = 13'd5000;
  parameter logic [6:0]  PRESS_IDLE_MAX  = 7'd120;
  parameter logic [5:0]  BLINK_TICKS_MAX = 6'd40;
  parameter logic [4:0]  BLINK_PERIODS   = 5'd30;
  parameter logic [8:0]  PAIR_HOLD       = 9'd200;
  parameter logic [8:0]  MODE_HOLD       = 9'd300;
  parameter logic [2:0]  PAIR_PRESSES    = 3'd6;
  parameter logic [2:0]  MODE_PRESSES    = 3'd1;
  parameter logic [2:0]  PRESS_SAT       = 3'd7;
  parameter logic [3:0]  SENSOR_BLINK    = 4'd15;
  parameter logic [9:0]  MS_PER_SECOND   = 10'd1000;
  parameter logic [15:0] DEFAULT_OFF_SEC = 16'd30;

endpackage

[rtl/touch_relay_switch_controller.sv]
// touch relay switch controller: tick driven switch, pairing and sensor mode logic
//
//   channel   dir   handshake                      payload
//   s_axis    in    s_axis_tvalid / s_axis_tready  tdata: pads, presence; tuser: cmd
//   m_axis    out   m_axis_tvalid / m_axis_tready  tdata: relay, leds, report, pulses
//   cfg       in    cfg_we_i                       cfg_wdata_i: auto off seconds
//
// one word accepted per cycle unless the output stalls; its result word is in the output
// register in the cycle after. the state update is a single pass of counters and compares.
// s_axis_tready is high while the output register is empty or being drained,
// so an output stall holds the input back by exactly one word.
// reset clears all state, the off delay register and the output register.
module touch_relay_switch_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] pad_pressed, [3] presence, [7:4] zero
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [2:0] relay_on, [5:3] led_red, [8:6] led_blue,
                                      // [9] sensor_led, [10] touch_led,
                                      // [13:11] report_mask, [14] start_pairing,
                                      // [15] periodic_update
);

  logic [15:0] auto_off_q;
  logic [2:0]  sw_q, sw_d;
  logic [2:0]  was_q, was_d;
  logic [8:0]  hold_q [3];
  logic [8:0]  hold_d [3];
  logic [2:0]  press_q, press_d;
  logic [6:0]  idle_q, idle_d;
  logic        mode_q, mode_d;
  logic        blink_q, blink_d;
  logic [5:0]  bticks_q, bticks_d;
  logic [4:0]  bper_q, bper_d;
  logic [7:0]  led_q, led_d;
  logic [3:0]  sblink_q, sblink_d;
  logic        armed_q, armed_d;
  logic        run_q, run_d;
  logic [15:0] secs_q, secs_d;
  logic [9:0]  ms_q, ms_d;
  logic [12:0] upd_q, upd_d;
  logic        valid_q;
  tsc_pkg::result_t res_q, res_d;
  logic        load;

  logic [2:0]  pads;
  logic        presence;
  tsc_pkg::cmd_e cmd;

  assign pads     = s_axis_tdata[2:0];
  assign presence = s_axis_tdata[3];
  assign cmd      = tsc_pkg::cmd_e'(s_axis_tuser);

  assign s_axis_tready = ~valid_q | m_axis_tready;
  assign load          = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q;

  always_comb begin
    logic [2:0] report;
    logic       pairing;
    logic       periodic;
    sw_d     = sw_q;
    was_d    = was_q;
    hold_d   = hold_q;
    press_d  = press_q;
    idle_d   = idle_q;
    mode_d   = mode_q;
    blink_d  = blink_q;
    bticks_d = bticks_q;
    bper_d   = bper_q;
    led_d    = led_q;
    sblink_d = sblink_q;
    armed_d  = armed_q;
    run_d    = run_q;
    secs_d   = secs_q;
    ms_d     = ms_q;
    upd_d    = upd_q;
    report   = '0;
    pairing  = 1'b0;
    periodic = 1'b0;

    if (cmd == tsc_pkg::CMD_COUNTDOWN) begin
      if (run_q && armed_q) begin
        if (ms_q >= tsc_pkg::MS_PER_SECOND) begin
          if (secs_q > 16'd1) begin
            secs_d = secs_q - 16'd1;
          end else if (secs_q == 16'd1) begin
            sw_d[2]   = 1'b0;
            report[2] = 1'b1;
            secs_d    = auto_off_q;
            run_d     = 1'b0;
            armed_d   = 1'b0;
          end
          ms_d = '0;
        end else begin
          ms_d = ms_q + 10'd1;
        end
      end
    end else begin
      if (upd_q >= tsc_pkg::UPDATE_PERIOD) begin
        periodic = 1'b1;
        upd_d    = '0;
      end else begin
        upd_d = upd_q + 13'd1;
      end

      if (idle_q > tsc_pkg::PRESS_IDLE_MAX) begin
        press_d = '0;
        idle_d  = '0;
      end else begin
        idle_d = idle_q + 7'd1;
      end

      if (bticks_q >= tsc_pkg::BLINK_TICKS_MAX) begin
        bticks_d = '0;
        if (blink_q) begin
          led_d[2:0] = '0;
          led_d[7:6] = '0;
          if (bper_q > tsc_pkg::BLINK_PERIODS) begin
            blink_d = 1'b0;
            bper_d  = '0;
          end else begin
            bper_d = bper_q + 5'd1;
          end
          led_d[5:3] = ~led_d[5:3];
        end else begin
          bper_d = '0;
        end
      end else begin
        bticks_d = bticks_q + 6'd1;
      end

      // pads in order, the press count carries from one pad to the next
      for (int i = 0; i < 3; i++) begin
        if (pads[i]) begin
          idle_d = '0;
          if (i == 2 && press_d == tsc_pkg::MODE_PRESSES) begin
            if (hold_d[i] >= tsc_pkg::MODE_HOLD) begin
              hold_d[i] = tsc_pkg::MODE_HOLD;
              mode_d    = ~mode_d;
              press_d   = '0;
            end else begin
              hold_d[i] = hold_d[i] + 9'd1;
            end
          end else if (press_d == tsc_pkg::PAIR_PRESSES) begin
            if (hold_d[i] > tsc_pkg::PAIR_HOLD) begin
              hold_d[i] = tsc_pkg::PAIR_HOLD;
              pairing   = 1'b1;
              blink_d   = 1'b1;
              press_d   = '0;
            end else begin
              hold_d[i] = hold_d[i] + 9'd1;
            end
          end
          if (!was_d[i]) begin
            was_d[i] = 1'b1;
            if (i != 2 || !mode_d) begin
              sw_d[i] = ~sw_d[i];
            end
            report[i] = 1'b1;
            if (press_d < tsc_pkg::PRESS_SAT) begin
              press_d = press_d + 3'd1;
            end
          end
        end else begin
          was_d[i]  = 1'b0;
          hold_d[i] = '0;
        end
      end

      if (!blink_d) begin
        if (!mode_d) begin
          led_d[7] = 1'b1;
          led_d[6] = 1'b0;
        end else begin
          led_d[7] = 1'b0;
          if (presence) begin
            sw_d[2]   = 1'b1;
            report[2] = 1'b1;
            armed_d   = 1'b1;
            secs_d    = (auto_off_q != '0) ? auto_off_q : tsc_pkg::DEFAULT_OFF_SEC;
            if (sblink_q >= tsc_pkg::SENSOR_BLINK) begin
              led_d[6] = ~led_d[6];
              sblink_d = '0;
            end else begin
              sblink_d = sblink_q + 4'd1;
            end
          end else begin
            led_d[6] = 1'b1;
            run_d    = 1'b1;
          end
        end
        led_d[2:0] = ~sw_d;
        led_d[5:3] = sw_d;
      end
    end

    res_d.relay_on        = sw_d;
    res_d.led_red         = led_d[2:0];
    res_d.led_blue        = led_d[5:3];
    res_d.sensor_led      = led_d[6];
    res_d.touch_led       = led_d[7];
    res_d.report_mask     = report;
    res_d.start_pairing   = pairing;
    res_d.periodic_update = periodic;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_off_q <= '0;
      sw_q       <= '0;
      was_q      <= '0;
      hold_q     <= '{default: '0};
      press_q    <= '0;
      idle_q     <= '0;
      mode_q     <= 1'b0;
      blink_q    <= 1'b0;
      bticks_q   <= '0;
      bper_q     <= '0;
      led_q      <= '0;
      sblink_q   <= '0;
      armed_q    <= 1'b0;
      run_q      <= 1'b0;
      secs_q     <= '0;
      ms_q       <= '0;
      upd_q      <= '0;
      valid_q    <= 1'b0;
      res_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        auto_off_q <= cfg_wdata_i;
      end
      if (load) begin
        sw_q     <= sw_d;
        was_q    <= was_d;
        hold_q   <= hold_d;
        press_q  <= press_d;
        idle_q   <= idle_d;
        mode_q   <= mode_d;
        blink_q  <= blink_d;
        bticks_q <= bticks_d;
        bper_q   <= bper_d;
        led_q    <= led_d;
        sblink_q <= sblink_d;
        armed_q  <= armed_d;
        run_q    <= run_d;
        secs_q   <= secs_d;
        ms_q     <= ms_d;
        upd_q    <= upd_d;
        res_q    <= res_d;
        valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_relay_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> res_q.relay_on == sw_q)
    else $error("relay word does not match switch state");

  a_pairing_starts_blink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (!res_q.start_pairing || blink_q))
    else $error("pairing pulse without config blinking");

  a_countdown_no_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cmd == tsc_pkg::CMD_COUNTDOWN) |=>
      (!res_q.start_pairing && !res_q.periodic_update))
    else $error("pulse on a countdown tick");

  a_hold_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q[0] <= 9'd201 && hold_q[1] <= 9'd201 && hold_q[2] <= tsc_pkg::MODE_HOLD)
    else $error("hold counter out of range");

  a_ms_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ms_q <= tsc_pkg::MS_PER_SECOND)
    else $error("millisecond counter out of range");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench of the touch relay switch controller, with its own tick predictor
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1650;

  typedef struct packed {
    tsc_pkg::cmd_e cmd;
    logic [2:0]    pads;
    logic          presence;
  } tick_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [2:0] pad_pressed, [3] presence, [7:4] zero
  logic        s_axis_tuser  = 1'b0; // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // relay_on, led_red, led_blue, sensor_led, touch_led,
                                     // report_mask, start_pairing, periodic_update

  touch_relay_switch_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // predicted switch state, all zero after reset
  logic [15:0] off_delay_cfg = '0;
  logic [2:0]  sw_on         = '0;
  logic [2:0]  pad_held      = '0;
  logic [8:0]  hold_cnt [3]  = '{default: '0};
  logic [2:0]  presses       = '0;
  logic [6:0]  idle_ticks    = '0;
  logic        mode_sensor   = 1'b0;
  logic        blinking      = 1'b0;
  logic [5:0]  blink_tick    = '0;
  logic [4:0]  blink_prd     = '0;
  logic [7:0]  leds          = '0;   // [2:0] red, [5:3] blue, [6] sensor, [7] touch
  logic [3:0]  sblink        = '0;
  logic        armed         = 1'b0;
  logic        cd_running    = 1'b0;
  logic [15:0] secs_left     = '0;
  logic [9:0]  ms_cnt        = '0;
  logic [12:0] upd_cnt       = '0;

  tick_t            ticks_to_send [$];
  tsc_pkg::result_t switch_results_due [$];
  tick_t            on_bus;
  int unsigned n_queued, n_checked, n_errors, cycle_count;
  int unsigned stall_odds, src_gap, sink_gap;
  logic        calm = 1'b0;

  function automatic tsc_pkg::result_t switch_step(tick_t t);
    tsc_pkg::result_t r;
    logic [2:0] report;
    logic       pairing;
    logic       periodic;
    report   = '0;
    pairing  = 1'b0;
    periodic = 1'b0;
    if (t.cmd == tsc_pkg::CMD_COUNTDOWN) begin
      if (cd_running && armed) begin
        if (ms_cnt >= tsc_pkg::MS_PER_SECOND) begin
          if (secs_left > 16'd1) begin
            secs_left = secs_left - 16'd1;
          end else if (secs_left == 16'd1) begin
            sw_on[2]   = 1'b0;
            report[2]  = 1'b1;
            secs_left  = off_delay_cfg;
            cd_running = 1'b0;
            armed      = 1'b0;
          end
          ms_cnt = '0;
        end else begin
          ms_cnt = ms_cnt + 10'd1;
        end
      end
    end else begin
      if (upd_cnt >= tsc_pkg::UPDATE_PERIOD) begin
        periodic = 1'b1;
        upd_cnt  = '0;
      end else begin
        upd_cnt = upd_cnt + 13'd1;
      end
      if (idle_ticks > tsc_pkg::PRESS_IDLE_MAX) begin
        presses    = '0;
        idle_ticks = '0;
      end else begin
        idle_ticks = idle_ticks + 7'd1;
      end
      if (blink_tick >= tsc_pkg::BLINK_TICKS_MAX) begin
        blink_tick = '0;
        if (blinking) begin
          leds[2:0] = '0;
          leds[7:6] = '0;
          if (blink_prd > tsc_pkg::BLINK_PERIODS) begin
            blinking  = 1'b0;
            blink_prd = '0;
          end else begin
            blink_prd = blink_prd + 5'd1;
          end
          leds[5:3] = ~leds[5:3];
        end else begin
          blink_prd = '0;
        end
      end else begin
        blink_tick = blink_tick + 6'd1;
      end
      for (int i = 0; i < 3; i++) begin
        if (t.pads[i]) begin
          idle_ticks = '0;
          if (i == 2 && presses == tsc_pkg::MODE_PRESSES) begin
            if (hold_cnt[2] >= tsc_pkg::MODE_HOLD) begin
              hold_cnt[2] = tsc_pkg::MODE_HOLD;
              mode_sensor = ~mode_sensor;
              presses     = '0;
            end else begin
              hold_cnt[2] = hold_cnt[2] + 9'd1;
            end
          end else if (presses == tsc_pkg::PAIR_PRESSES) begin
            if (hold_cnt[i] > tsc_pkg::PAIR_HOLD) begin
              hold_cnt[i] = tsc_pkg::PAIR_HOLD;
              pairing     = 1'b1;
              blinking    = 1'b1;
              presses     = '0;
            end else begin
              hold_cnt[i] = hold_cnt[i] + 9'd1;
            end
          end
          if (!pad_held[i]) begin
            pad_held[i] = 1'b1;
            // in sensor mode pad 3 no longer drives its switch
            if (i != 2 || !mode_sensor) sw_on[i] = ~sw_on[i];
            report[i] = 1'b1;
            if (presses < tsc_pkg::PRESS_SAT) presses = presses + 3'd1;
          end
        end else begin
          pad_held[i] = 1'b0;
          hold_cnt[i] = '0;
        end
      end
      if (!blinking) begin
        if (!mode_sensor) begin
          leds[7] = 1'b1;
          leds[6] = 1'b0;
        end else begin
          leds[7] = 1'b0;
          if (t.presence) begin
            sw_on[2]  = 1'b1;
            report[2] = 1'b1;
            armed     = 1'b1;
            secs_left = (off_delay_cfg != '0) ? off_delay_cfg : tsc_pkg::DEFAULT_OFF_SEC;
            if (sblink >= tsc_pkg::SENSOR_BLINK) begin
              leds[6] = ~leds[6];
              sblink  = '0;
            end else begin
              sblink = sblink + 4'd1;
            end
          end else begin
            leds[6]    = 1'b1;
            cd_running = 1'b1;
          end
        end
        leds[2:0] = ~sw_on;
        leds[5:3] = sw_on;
      end
    end
    r.relay_on        = sw_on;
    r.led_red         = leds[2:0];
    r.led_blue        = leds[5:3];
    r.sensor_led      = leds[6];
    r.touch_led       = leds[7];
    r.report_mask     = report;
    r.start_pairing   = pairing;
    r.periodic_update = periodic;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (n_errors < 40)
      $display("%0t ns: word %0d %s = %0h, expected %0h", $realtime, n_checked, what, got,
               want);
    n_errors++;
  endtask

  task automatic send_tick(input tsc_pkg::cmd_e c, input logic [2:0] pads,
                           input logic pres);
    tick_t t;
    t.cmd      = c;
    t.pads     = pads;
    t.presence = pres;
    ticks_to_send.push_back(t);
    n_queued++;
  endtask

  task automatic wait_settled();
    while (n_checked != n_queued) @(posedge clk_i);
  endtask

  task automatic set_off_delay(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v;
    off_delay_cfg  = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // long enough with no pad touched for the press count to clear
  task automatic send_idle_wait();
    repeat (124) send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n)
      send_tick(($urandom_range(0, 3) == 0) ? tsc_pkg::CMD_COUNTDOWN : tsc_pkg::CMD_PROCESS,
                3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_taps(input int unsigned n);
    logic [2:0] pad;
    repeat (n) begin
      pad = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7))
                                        : 3'b001 << $urandom_range(0, 2);
      repeat ($urandom_range(1, 3))
        send_tick(tsc_pkg::CMD_PROCESS, pad, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3))
        send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'($urandom_range(0, 1)));
    end
  endtask

  // six quick presses, the last one held around the pairing threshold
  task automatic send_pairing();
    int unsigned base;
    logic [2:0]  pad;
    base = 32'(presses);
    send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'($urandom_range(0, 1)));
    if (base > 5 || idle_ticks > 100) begin
      send_idle_wait();
      base = 0;
    end
    repeat (5 - base) begin
      pad = 3'b001 << $urandom_range(0, 2);
      repeat ($urandom_range(1, 2))
        send_tick(tsc_pkg::CMD_PROCESS, pad, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 2))
        send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'($urandom_range(0, 1)));
    end
    pad = 3'b001 << $urandom_range(0, 2);
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(195, 202) : $urandom_range(203, 215))
      send_tick(tsc_pkg::CMD_PROCESS, pad, 1'($urandom_range(0, 1)));
    send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'b0);
  endtask

  // one press of pad 3 held around the mode swap threshold
  task automatic send_mode_swap();
    send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'($urandom_range(0, 1)));
    if (presses != '0 || idle_ticks > 100) send_idle_wait();
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(296, 301) : $urandom_range(302, 310))
      send_tick(tsc_pkg::CMD_PROCESS, 3'b100, 1'($urandom_range(0, 1)));
    send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'($urandom_range(0, 1)));
  endtask

  // arm the off delay, then let it run out when it is one second
  task automatic send_expiry();
    int unsigned n;
    send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'b1);
    send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'b0);
    n = (off_delay_cfg == 16'd1) ? 1001 + $urandom_range(0, 40) : $urandom_range(100, 600);
    repeat (n) begin
      if ($urandom_range(0, 49) == 0)
        send_tick(tsc_pkg::CMD_PROCESS, 3'($urandom_range(0, 7)), 1'b0);
      else
        send_tick(tsc_pkg::CMD_COUNTDOWN, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
  endtask

  // source side: one word per handshake, random gaps between words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) switch_results_due.push_back(switch_step(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap == 0 && stall_odds != 0 && !calm && $urandom_range(1, stall_odds) == 1)
          src_gap = $urandom_range(1, 18);
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (ticks_to_send.size() != 0) begin
          on_bus         = ticks_to_send.pop_front();
          s_axis_tdata  <= {4'b0000, on_bus.presence, on_bus.pads};
          s_axis_tuser  <= on_bus.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: compare every result word with the oldest prediction
  always @(posedge clk_i) begin
    tsc_pkg::result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = tsc_pkg::result_t'(m_axis_tdata);
        if (switch_results_due.size() == 0) begin
          note_mismatch("unexpected word", 32'(m_axis_tdata), 0);
        end else begin
          want = switch_results_due.pop_front();
          if (got.relay_on !== want.relay_on)
            note_mismatch("relay_on", 32'(got.relay_on), 32'(want.relay_on));
          if (got.led_red !== want.led_red)
            note_mismatch("led_red", 32'(got.led_red), 32'(want.led_red));
          if (got.led_blue !== want.led_blue)
            note_mismatch("led_blue", 32'(got.led_blue), 32'(want.led_blue));
          if (got.sensor_led !== want.sensor_led)
            note_mismatch("sensor_led", 32'(got.sensor_led), 32'(want.sensor_led));
          if (got.touch_led !== want.touch_led)
            note_mismatch("touch_led", 32'(got.touch_led), 32'(want.touch_led));
          if (got.report_mask !== want.report_mask)
            note_mismatch("report_mask", 32'(got.report_mask), 32'(want.report_mask));
          if (got.start_pairing !== want.start_pairing)
            note_mismatch("start_pairing", 32'(got.start_pairing),
                          32'(want.start_pairing));
          if (got.periodic_update !== want.periodic_update)
            note_mismatch("periodic_update", 32'(got.periodic_update),
                          32'(want.periodic_update));
          n_checked++;
        end
      end
      if (sink_gap == 0 && stall_odds != 0 && !calm && $urandom_range(1, stall_odds) == 1)
        sink_gap = $urandom_range(1, 18);
      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n_random_start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_off_delay(16'hFFFF);

    // countdown before anything is armed: the ms counter must hold
    send_tick(tsc_pkg::CMD_COUNTDOWN, 3'b111, 1'b1);
    send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'b0);
    // all pads at once, twelve presses in all: the press count saturates
    for (int k = 0; k < 4; k++) begin
      send_tick(tsc_pkg::CMD_PROCESS, 3'b111, k[0]);
      send_tick(tsc_pkg::CMD_PROCESS, 3'b000, ~k[0]);
    end
    for (int p = 0; p < 3; p++) begin
      send_tick(tsc_pkg::CMD_PROCESS, 3'b001 << p, 1'b1);
      send_tick(tsc_pkg::CMD_PROCESS, 3'b000, 1'b0);
    end
    send_tick(tsc_pkg::CMD_COUNTDOWN, 3'b000, 1'b0);
    send_tick(tsc_pkg::CMD_PROCESS, 3'b011, 1'b1);
    send_tick(tsc_pkg::CMD_PROCESS, 3'b110, 1'b0);
    wait_settled();

    n_random_start = n_queued;
    while (n_queued - n_random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       set_off_delay(16'd0);
          1:       set_off_delay(16'hFFFF);
          2, 3:    set_off_delay(16'd1);
          4:       set_off_delay(16'd2);
          default: set_off_delay(16'($urandom_range(0, 65535)));
        endcase
      end
      case ($urandom_range(0, 3))
        0:       stall_odds = 0;
        1:       stall_odds = 3;
        2:       stall_odds = 8;
        default: stall_odds = 24;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 12)
        send_pairing();
      else if (pick < 30 || (pick < 55 && !mode_sensor))
        send_mode_swap();
      else if (pick < 55)
        send_expiry();
      else if (pick < 75)
        send_taps($urandom_range(2, 12));
      else
        send_noise($urandom_range(10, 60));
      send_noise($urandom_range(0, 8));
      wait_settled();
    end

    // closing stretch at full rate on both sides
    calm = 1'b1;
    set_off_delay(16'd0);
    send_noise(80);
    wait_settled();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0 && switch_results_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
